// ----- design/spd_pkg.sv -----
`timescale 1ns / 1ps

package spd_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_W     = 25;
    localparam int LANES      = 4;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CMAG_W = 2 * COORD_BITS + 1;
    localparam int LO_W   = COORD_BITS + 1;
    localparam int HI_W   = CMAG_W - LO_W;
    localparam int SQ_W   = 2 * CMAG_W;
    localparam int DEN_W  = 2 * COORD_BITS + 2;
    localparam int QUO_W  = 2 * COORD_BITS + 2 + 2 * FRAC_BITS;
    localparam int NUM_W  = SQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W = QUO_W / 2;
    localparam int SREM_W = ROOT_W + 2;

    // front stages, divider (init + one per quotient bit), min tree, root steps
    localparam int N_STG  = 5 + (QUO_W + 1) + 2 + ROOT_W;
    localparam int TCH_N  = N_STG - 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax0;
        logic signed [COORD_BITS-1:0] ay0;
        logic signed [COORD_BITS-1:0] ax1;
        logic signed [COORD_BITS-1:0] ay1;
        logic signed [COORD_BITS-1:0] bx0;
        logic signed [COORD_BITS-1:0] by0;
        logic signed [COORD_BITS-1:0] bx1;
        logic signed [COORD_BITS-1:0] by1;
    } t_seg_req;

    typedef struct packed {
        logic [DIST_W-1:0] distance_q8;
        logic              touching;
    } t_seg_rsp;

endpackage

// ----- design/segment_pair_distance.sv -----
`timescale 1ns / 1ps

// Throughput: one request per cycle; the whole pipe holds while a result is stalled.
// Depth is set by the restoring divider (one quotient bit per stage) and the
// square root (one root bit per stage). Reset clears all valid bits only.
module segment_pair_distance
    import spd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_seg_req i_req,
    output logic     o_valid,
    input  logic     i_stall,
    output t_seg_rsp o_rsp
);

    logic en;

    logic signed [COORD_BITS-1:0] px [LANES];
    logic signed [COORD_BITS-1:0] py [LANES];
    logic signed [COORD_BITS-1:0] sx [LANES];
    logic signed [COORD_BITS-1:0] sy [LANES];
    logic signed [COORD_BITS-1:0] ex [LANES];
    logic signed [COORD_BITS-1:0] ey [LANES];

    logic [N_STG-1:0] r_vld;
    logic [TCH_N-1:0] r_tch;
    logic             n_tch;

    logic signed [DIFF_W-1:0] r1_dx [LANES], n1_dx [LANES];
    logic signed [DIFF_W-1:0] r1_dy [LANES], n1_dy [LANES];
    logic signed [DIFF_W-1:0] r1_wx [LANES], n1_wx [LANES];
    logic signed [DIFF_W-1:0] r1_wy [LANES], n1_wy [LANES];
    logic signed [DIFF_W-1:0] r1_vx [LANES], n1_vx [LANES];
    logic signed [DIFF_W-1:0] r1_vy [LANES], n1_vy [LANES];
    logic [LANES-1:0]         r1_box, n1_box;

    logic signed [PROD_W-1:0] r2_dxx [LANES], r2_dyy [LANES];
    logic signed [PROD_W-1:0] r2_wxx [LANES], r2_wyy [LANES];
    logic signed [PROD_W-1:0] r2_vxx [LANES], r2_vyy [LANES];
    logic signed [PROD_W-1:0] r2_ptx [LANES], r2_pty [LANES];
    logic signed [PROD_W-1:0] r2_cra [LANES], r2_crb [LANES];
    logic [LANES-1:0]         r2_box;

    logic [DEN_W-1:0]        r3_len2 [LANES];
    logic [DEN_W-1:0]        r3_w2 [LANES];
    logic [DEN_W-1:0]        r3_v2 [LANES];
    logic signed [SUM_W-1:0] r3_dot [LANES];
    logic signed [SUM_W-1:0] r3_c [LANES];
    logic [LANES-1:0]        r3_box;

    logic [LANES-1:0]  r4_int, n4_int;
    logic [DEN_W-1:0]  r4_plain [LANES], n4_plain [LANES];
    logic [CMAG_W-1:0] r4_ac [LANES], n4_ac [LANES];
    logic [DEN_W-1:0]  r4_den [LANES];

    logic [2*HI_W-1:0]      r5_hh [LANES];
    logic [HI_W+LO_W-1:0]   r5_hl [LANES];
    logic [2*LO_W-1:0]      r5_ll [LANES];
    logic [LANES-1:0]       r5_int;
    logic [DEN_W-1:0]       r5_plain [LANES];
    logic [DEN_W-1:0]       r5_den [LANES];

    logic [DEN_W-1:0] r_dv_rem [LANES][QUO_W+1], n_dv_rem [LANES][QUO_W+1];
    logic [QUO_W-1:0] r_dv_nq  [LANES][QUO_W+1], n_dv_nq  [LANES][QUO_W+1];
    logic [DEN_W-1:0] r_dv_den [LANES][QUO_W+1], n_dv_den [LANES][QUO_W+1];

    logic [QUO_W-1:0] r_mn_a [2], n_mn_a [2];
    logic [QUO_W-1:0] r_mn, n_mn;

    logic [QUO_W-1:0]  r_sq_x [ROOT_W], n_sq_x [ROOT_W];
    logic [SREM_W-1:0] r_sq_rem [ROOT_W], n_sq_rem [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W], n_sq_root [ROOT_W];

    assign en      = !r_vld[N_STG-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[N_STG-1];
    assign o_rsp.touching    = r_tch[TCH_N-1];
    assign o_rsp.distance_q8 = r_tch[TCH_N-1] ? '0 : DIST_W'(r_sq_root[ROOT_W-1]);

    // lanes: A0 vs B, A1 vs B, B0 vs A, B1 vs A
    always_comb begin
        px[0] = i_req.ax0; py[0] = i_req.ay0;
        px[1] = i_req.ax1; py[1] = i_req.ay1;
        px[2] = i_req.bx0; py[2] = i_req.by0;
        px[3] = i_req.bx1; py[3] = i_req.by1;
        for (int l = 0; l < 2; l++) begin
            sx[l] = i_req.bx0; sy[l] = i_req.by0;
            ex[l] = i_req.bx1; ey[l] = i_req.by1;
        end
        for (int l = 2; l < LANES; l++) begin
            sx[l] = i_req.ax0; sy[l] = i_req.ay0;
            ex[l] = i_req.ax1; ey[l] = i_req.ay1;
        end
        for (int l = 0; l < LANES; l++) begin
            n1_dx[l] = DIFF_W'(ex[l]) - DIFF_W'(sx[l]);
            n1_dy[l] = DIFF_W'(ey[l]) - DIFF_W'(sy[l]);
            n1_wx[l] = DIFF_W'(px[l]) - DIFF_W'(sx[l]);
            n1_wy[l] = DIFF_W'(py[l]) - DIFF_W'(sy[l]);
            n1_vx[l] = DIFF_W'(px[l]) - DIFF_W'(ex[l]);
            n1_vy[l] = DIFF_W'(py[l]) - DIFF_W'(ey[l]);
            n1_box[l] = ((px[l] >= sx[l] && px[l] <= ex[l]) ||
                         (px[l] >= ex[l] && px[l] <= sx[l])) &&
                        ((py[l] >= sy[l] && py[l] <= ey[l]) ||
                         (py[l] >= ey[l] && py[l] <= sy[l]));
        end
    end

    // stage 4: case select, |cross|, contact test
    always_comb begin
        logic [LANES-1:0] pos;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] zer;
        logic signed [SUM_W-1:0] mag;
        for (int l = 0; l < LANES; l++) begin
            zer[l] = (r3_c[l] == '0);
            neg[l] = r3_c[l][SUM_W-1];
            pos[l] = !zer[l] && !neg[l];
            n4_int[l] = (r3_len2[l] != '0) && (r3_dot[l] > 0) &&
                        (r3_dot[l] < $signed({1'b0, r3_len2[l]}));
            n4_plain[l] = ((r3_len2[l] == '0) || (r3_dot[l] <= 0)) ? r3_w2[l] : r3_v2[l];
            mag = neg[l] ? -r3_c[l] : r3_c[l];
            n4_ac[l] = mag[CMAG_W-1:0];
        end
        n_tch = (((pos[0] && neg[1]) || (neg[0] && pos[1])) &&
                 ((pos[2] && neg[3]) || (neg[2] && pos[3])))
              || (zer[0] && r3_box[0]) || (zer[1] && r3_box[1])
              || (zer[2] && r3_box[2]) || (zer[3] && r3_box[3]);
    end

    // divider: load, then one restoring step per stage; then a two-level min over the lanes
    always_comb begin
        logic [SQ_W-1:0]  sq;
        logic [NUM_W-1:0] num;
        logic [DEN_W:0]   t;
        logic             ge;
        logic [DEN_W:0]   diff;
        for (int l = 0; l < LANES; l++) begin
            sq = (SQ_W'(r5_hh[l]) << (2 * LO_W)) + (SQ_W'(r5_hl[l]) << (LO_W + 1))
               + SQ_W'(r5_ll[l]);
            if (r5_int[l]) begin
                num = NUM_W'(sq) << (2 * FRAC_BITS);
                n_dv_den[l][0] = r5_den[l];
            end else begin
                num = NUM_W'(r5_plain[l]) << (2 * FRAC_BITS);
                n_dv_den[l][0] = DEN_W'(1);
            end
            n_dv_rem[l][0] = DEN_W'(num[NUM_W-1:QUO_W]);
            n_dv_nq[l][0]  = num[QUO_W-1:0];
            for (int k = 1; k <= QUO_W; k++) begin
                t    = {r_dv_rem[l][k-1], r_dv_nq[l][k-1][QUO_W-1]};
                ge   = (t >= {1'b0, r_dv_den[l][k-1]});
                diff = t - {1'b0, r_dv_den[l][k-1]};
                n_dv_rem[l][k] = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                n_dv_nq[l][k]  = {r_dv_nq[l][k-1][QUO_W-2:0], ge};
                n_dv_den[l][k] = r_dv_den[l][k-1];
            end
        end
        n_mn_a[0] = (r_dv_nq[0][QUO_W] < r_dv_nq[1][QUO_W]) ?
                    r_dv_nq[0][QUO_W] : r_dv_nq[1][QUO_W];
        n_mn_a[1] = (r_dv_nq[2][QUO_W] < r_dv_nq[3][QUO_W]) ?
                    r_dv_nq[2][QUO_W] : r_dv_nq[3][QUO_W];
        n_mn      = (r_mn_a[0] < r_mn_a[1]) ? r_mn_a[0] : r_mn_a[1];
    end

    // square root: one result bit per stage
    always_comb begin
        logic [QUO_W-1:0]  x;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;
        logic [SREM_W+1:0] diff;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                x = r_mn; rem = '0; root = '0;
            end else begin
                x = r_sq_x[k-1]; rem = r_sq_rem[k-1]; root = r_sq_root[k-1];
            end
            t     = {rem, x[QUO_W-1 -: 2]};
            trial = (SREM_W+2)'({root, 2'b01});
            diff  = t - trial;
            n_sq_x[k] = x << 2;
            if (t >= trial) begin
                n_sq_rem[k]  = diff[SREM_W-1:0];
                n_sq_root[k] = {root[ROOT_W-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = t[SREM_W-1:0];
                n_sq_root[k] = {root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_STG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tch <= {r_tch[TCH_N-2:0], n_tch};
            r1_dx <= n1_dx; r1_dy <= n1_dy;
            r1_wx <= n1_wx; r1_wy <= n1_wy;
            r1_vx <= n1_vx; r1_vy <= n1_vy;
            r1_box <= n1_box;
            for (int l = 0; l < LANES; l++) begin
                r2_dxx[l] <= r1_dx[l] * r1_dx[l];
                r2_dyy[l] <= r1_dy[l] * r1_dy[l];
                r2_wxx[l] <= r1_wx[l] * r1_wx[l];
                r2_wyy[l] <= r1_wy[l] * r1_wy[l];
                r2_vxx[l] <= r1_vx[l] * r1_vx[l];
                r2_vyy[l] <= r1_vy[l] * r1_vy[l];
                r2_ptx[l] <= r1_wx[l] * r1_dx[l];
                r2_pty[l] <= r1_wy[l] * r1_dy[l];
                r2_cra[l] <= r1_dx[l] * r1_wy[l];
                r2_crb[l] <= r1_dy[l] * r1_wx[l];

                r3_len2[l] <= $unsigned(r2_dxx[l]) + $unsigned(r2_dyy[l]);
                r3_w2[l]   <= $unsigned(r2_wxx[l]) + $unsigned(r2_wyy[l]);
                r3_v2[l]   <= $unsigned(r2_vxx[l]) + $unsigned(r2_vyy[l]);
                r3_dot[l]  <= SUM_W'(r2_ptx[l]) + SUM_W'(r2_pty[l]);
                r3_c[l]    <= SUM_W'(r2_cra[l]) - SUM_W'(r2_crb[l]);

                r4_den[l] <= r3_len2[l];

                r5_hh[l] <= r4_ac[l][CMAG_W-1:LO_W] * r4_ac[l][CMAG_W-1:LO_W];
                r5_hl[l] <= r4_ac[l][CMAG_W-1:LO_W] * r4_ac[l][LO_W-1:0];
                r5_ll[l] <= r4_ac[l][LO_W-1:0] * r4_ac[l][LO_W-1:0];
                r5_plain[l] <= r4_plain[l];
                r5_den[l]   <= r4_den[l];
            end
            r2_box   <= r1_box;
            r3_box   <= r2_box;
            r4_int   <= n4_int;
            r4_plain <= n4_plain;
            r4_ac    <= n4_ac;
            r5_int   <= r4_int;
            r_dv_rem <= n_dv_rem;
            r_dv_nq  <= n_dv_nq;
            r_dv_den <= n_dv_den;
            r_mn_a   <= n_mn_a;
            r_mn     <= n_mn;
            r_sq_x    <= n_sq_x;
            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
        end
    end

endmodule

// ----- sim/segment_pair_distance_test.sv -----
`timescale 1ns / 1ps

module segment_pair_distance_test;
    import spd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_seg_req i_req;
    logic     o_valid;
    logic     i_stall;
    t_seg_rsp o_rsp;

    t_seg_rsp pending_dist[$];
    int       mismatches;
    int       cycles;
    int       src_idle_pct;
    int       snk_stall_pct;

    segment_pair_distance u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  q;
        logic [127:0] c;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            c = {64'b0, q | (64'd1 << b)};
            if (c * c <= n) q = c[63:0];
        end
        return q;
    endfunction

    function automatic logic [63:0] root_of_ratio(logic [127:0] num, logic [63:0] den);
        logic [127:0] quo;
        quo = (num << (2 * FRAC_BITS)) / {64'b0, den};
        return isqrt(quo);
    endfunction

    function automatic logic [63:0] endpoint_dist(longint dx, longint dy);
        return root_of_ratio({64'b0, 64'(dx * dx + dy * dy)}, 64'd1);
    endfunction

    function automatic logic [63:0] point_to_seg(longint px, longint py, longint sx,
                                                 longint sy, longint ex, longint ey);
        longint       dx, dy, wx, wy, len2, dot, c;
        logic [127:0] sq;
        dx = ex - sx; dy = ey - sy;
        wx = px - sx; wy = py - sy;
        len2 = dx * dx + dy * dy;
        if (len2 == 0) return endpoint_dist(wx, wy);
        dot = wx * dx + wy * dy;
        if (dot <= 0) return endpoint_dist(wx, wy);
        if (dot >= len2) return endpoint_dist(px - ex, py - ey);
        c = dx * wy - dy * wx;
        if (c < 0) c = -c;
        sq = {64'b0, 64'(c)};
        return root_of_ratio(sq * sq, 64'(len2));
    endfunction

    function automatic int turn_sign(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
        longint v;
        v = (qx - px) * (ry - py) - (qy - py) * (rx - px);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic bit within_box(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
        return rx >= ((px < qx) ? px : qx) && rx <= ((px < qx) ? qx : px) &&
               ry >= ((py < qy) ? py : qy) && ry <= ((py < qy) ? qy : py);
    endfunction

    function automatic t_seg_rsp predict_distance(t_seg_req r);
        longint      ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        int          d1, d2, d3, d4;
        bit          touch;
        logic [63:0] best, v;
        t_seg_rsp    res;
        ax0 = r.ax0; ay0 = r.ay0; ax1 = r.ax1; ay1 = r.ay1;
        bx0 = r.bx0; by0 = r.by0; bx1 = r.bx1; by1 = r.by1;
        d1 = turn_sign(bx0, by0, bx1, by1, ax0, ay0);
        d2 = turn_sign(bx0, by0, bx1, by1, ax1, ay1);
        d3 = turn_sign(ax0, ay0, ax1, ay1, bx0, by0);
        d4 = turn_sign(ax0, ay0, ax1, ay1, bx1, by1);
        touch = (d1 * d2 < 0 && d3 * d4 < 0)
            || (d1 == 0 && within_box(bx0, by0, bx1, by1, ax0, ay0))
            || (d2 == 0 && within_box(bx0, by0, bx1, by1, ax1, ay1))
            || (d3 == 0 && within_box(ax0, ay0, ax1, ay1, bx0, by0))
            || (d4 == 0 && within_box(ax0, ay0, ax1, ay1, bx1, by1));
        best = '0;
        if (!touch) begin
            best = point_to_seg(ax0, ay0, bx0, by0, bx1, by1);
            v = point_to_seg(ax1, ay1, bx0, by0, bx1, by1);
            if (v < best) best = v;
            v = point_to_seg(bx0, by0, ax0, ay0, ax1, ay1);
            if (v < best) best = v;
            v = point_to_seg(bx1, by1, ax0, ay0, ax1, ay1);
            if (v < best) best = v;
        end
        res.distance_q8 = best[DIST_W-1:0];
        res.touching    = touch;
        return res;
    endfunction

    // ---------------- driving ----------------
    task automatic send_req(t_seg_req r);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        pending_dist.push_back(predict_distance(r));
        @(negedge i_clk);
    endtask

    function automatic t_seg_req make_req(int a0x, int a0y, int a1x, int a1y,
                                          int b0x, int b0y, int b1x, int b1y);
        t_seg_req r;
        r.ax0 = COORD_BITS'(a0x); r.ay0 = COORD_BITS'(a0y);
        r.ax1 = COORD_BITS'(a1x); r.ay1 = COORD_BITS'(a1y);
        r.bx0 = COORD_BITS'(b0x); r.by0 = COORD_BITS'(b0y);
        r.bx1 = COORD_BITS'(b1x); r.by1 = COORD_BITS'(b1y);
        return r;
    endfunction

    always @(negedge i_clk)
        i_stall <= (snk_stall_pct > 0) && ($urandom_range(99) < snk_stall_pct);

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_seg_rsp want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dist.size() == 0) begin
                report_mismatch("unexpected response", 1, 0);
            end else begin
                want = pending_dist.pop_front();
                if (o_rsp.distance_q8 !== want.distance_q8)
                    report_mismatch("distance_q8", longint'(o_rsp.distance_q8),
                                    longint'(want.distance_q8));
                if (o_rsp.touching !== want.touching)
                    report_mismatch("touching", longint'(o_rsp.touching),
                                    longint'(want.touching));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_touching();
        send_req(make_req(0, 0, 10, 10, 0, 10, 10, 0));          // proper cross
        send_req(make_req(0, 0, 10, 0, 10, 0, 20, 5));           // shared endpoint
        send_req(make_req(0, 0, 10, 0, 5, 0, 15, 0));            // collinear overlap
        send_req(make_req(0, 0, 10, 0, 5, 0, 5, 7));             // T junction
        send_req(make_req(3, 4, 3, 4, 3, 4, 3, 4));              // equal points
        send_req(make_req(3, 4, 3, 4, 0, 0, 6, 8));              // point on segment
        send_req(make_req(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    endtask

    task automatic test_disjoint();
        send_req(make_req(0, 0, 10, 0, 12, 0, 20, 0));           // collinear gap
        send_req(make_req(0, 0, 10, 0, 0, 3, 10, 3));            // parallel
        send_req(make_req(0, 0, 10, 0, 5, 1, 5, 9));             // projection interior
        send_req(make_req(0, 0, 10, 0, -3, 4, -9, 9));           // beyond start
        send_req(make_req(0, 0, 1, 1, 2, 0, 3, -1));
    endtask

    task automatic test_degenerate();
        send_req(make_req(0, 0, 0, 0, 3, 4, 3, 4));              // two distinct points
        send_req(make_req(1, 1, 1, 1, 5, -7, 9, 2));             // point vs segment
        send_req(make_req(5, -7, 9, 2, 1, 1, 1, 1));
        send_req(make_req(0, 0, 0, 0, 1, 0, 1, 0));
    endtask

    task automatic test_extremes();
        send_req(make_req(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send_req(make_req(-32768, 32767, -32768, -32768, 32767, -32768, 32767, 32767));
        send_req(make_req(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32766));
        send_req(make_req(32767, 0, 32767, 1, -32768, -32768, -32767, 32767));
        send_req(make_req(-1, -1, -1, -1, 0, 0, 0, 0));
    endtask

    function automatic int clip16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    task automatic test_random_stream(int n);
        t_seg_req r;
        int cx, cy, dx, dy, k[4];
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: r = t_seg_req'({$urandom, $urandom, $urandom, $urandom});
                1: begin
                    cx = $urandom_range(64000) - 32000;
                    cy = $urandom_range(64000) - 32000;
                    r = make_req(cx + $urandom_range(16) - 8, cy + $urandom_range(16) - 8,
                                 cx + $urandom_range(16) - 8, cy + $urandom_range(16) - 8,
                                 cx + $urandom_range(16) - 8, cy + $urandom_range(16) - 8,
                                 cx + $urandom_range(16) - 8, cy + $urandom_range(16) - 8);
                end
                2: begin
                    cx = $urandom_range(64000) - 32000;
                    cy = $urandom_range(64000) - 32000;
                    dx = $urandom_range(16) - 8;
                    dy = $urandom_range(16) - 8;
                    foreach (k[j]) k[j] = $urandom_range(8) - 4;
                    r = make_req(cx + k[0] * dx, cy + k[0] * dy, cx + k[1] * dx, cy + k[1] * dy,
                                 cx + k[2] * dx, cy + k[2] * dy, cx + k[3] * dx, cy + k[3] * dy);
                end
                default: begin
                    cx = $urandom_range(65535) - 32768;
                    cy = $urandom_range(65535) - 32768;
                    dx = clip16(cx + $urandom_range(200) - 100);
                    dy = clip16(cy + $urandom_range(200) - 100);
                    if ($urandom_range(1))
                        r = make_req(cx, cy, cx, cy, dx, dy,
                                     $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
                    else
                        r = make_req(cx, cy, cx, cy, dx, dy, dx, dy);
                end
            endcase
            send_req(r);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_touching();
        test_disjoint();
        test_degenerate();
        test_extremes();
        test_random_stream(200);
        src_idle_pct = 83;
        test_random_stream(200);
        src_idle_pct = 0;
        snk_stall_pct = 83;
        test_random_stream(200);
        src_idle_pct = 16;
        snk_stall_pct = 16;
        test_random_stream(200);
        i_valid <= 1'b0;

        while (pending_dist.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
